// ===== hw/rtl/iaisd_pkg.sv =====
// Package for the indexed array list block: field widths, command, status,
// edit and state codes, and the structs passed along the row of cells.
// No dependencies.
`timescale 1ns / 1ps

package iaisd_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned CNT_OUT_W = 7;
	localparam int unsigned SUM_W     = 38;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_DELETE    = 3'd2,
		CMD_OVERWRITE = 3'd3,
		CMD_READ      = 3'd4,
		CMD_SEARCH    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADPOS   = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		EDIT_NONE,
		EDIT_INSERT,
		EDIT_DELETE,
		EDIT_WRITE
	} edit_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EDIT,
		S_SWEEP,
		S_DONE
	} state_t;

	// Edit command and data word broadcast to every cell.
	typedef struct packed {
		edit_op_t            op;
		logic [DATA_W-1:0]   value;
	} cell_ctrl_t;

	// Running partial results handed from one cell to the next.
	typedef struct packed {
		logic                any;
		logic [SUM_W-1:0]    sum;
		logic [DATA_W-1:0]   max_v;
		logic [DATA_W-1:0]   min_v;
		logic                found;
		logic [POS_W-1:0]    fpos;
		logic [DATA_W-1:0]   rd;
	} carry_t;

	localparam carry_t CARRY_INIT = '0;

endpackage

// ===== hw/rtl/iaisd_cell.sv =====
// One cell of the array row: holds one entry, applies shift and write edits,
// and folds its entry into the partial results passed to the right neighbor.
// Depends on iaisd_pkg.
`timescale 1ns / 1ps

module iaisd_cell import iaisd_pkg::*; #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CNT_W = 7,
	parameter int unsigned PW    = 7
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [PW-1:0]     pos,
	input  logic [CNT_W-1:0]  count,
	input  logic [DATA_W-1:0] left_entry,
	input  logic [DATA_W-1:0] right_entry,
	input  carry_t            carry_in,
	output logic [DATA_W-1:0] entry,
	output carry_t            carry_out
);

	localparam logic [PW-1:0]    IDX   = PW'(INDEX);
	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
	localparam logic [POS_W-1:0] IDX_P = POS_W'(INDEX);

	logic [DATA_W-1:0] entry_q, entry_d;
	carry_t            carry_q, carry_d;
	logic              valid;
	logic [SUM_W-1:0]  entry_ext;

	// Entry update: insert moves entries right, delete moves them left, write sets one.
	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			EDIT_INSERT: begin
				if (IDX > pos) begin
					entry_d = left_entry;
				end else if (IDX == pos) begin
					entry_d = ctrl.value;
				end
			end
			EDIT_DELETE: begin
				if (IDX >= pos) begin
					entry_d = right_entry;
				end
			end
			EDIT_WRITE: begin
				if (IDX == pos) begin
					entry_d = ctrl.value;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// Fold this entry into the running sum, extremes, search and read results.
	assign valid     = (IDX_C < count);
	assign entry_ext = {{(SUM_W-DATA_W){entry_q[DATA_W-1]}}, entry_q};

	always_comb begin
		carry_d = carry_in;
		if (valid) begin
			carry_d.any = 1'b1;
			carry_d.sum = carry_in.sum + entry_ext;
			if (!carry_in.any || ($signed(entry_q) > $signed(carry_in.max_v))) begin
				carry_d.max_v = entry_q;
			end
			if (!carry_in.any || ($signed(entry_q) < $signed(carry_in.min_v))) begin
				carry_d.min_v = entry_q;
			end
			if (!carry_in.found && (entry_q == ctrl.value)) begin
				carry_d.found = 1'b1;
				carry_d.fpos  = IDX_P;
			end
		end
		if (IDX == pos) begin
			carry_d.rd = entry_q;
		end
	end

	// Entry and partial results are payload and need no reset.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		carry_q <= carry_d;
	end

	assign entry     = entry_q;
	assign carry_out = carry_q;

endmodule

// ===== hw/rtl/indexed_array_insert_delete_search_top.sv =====
// Top level of the indexed array list: command decode, sequencer and the row
// of DEPTH cells that holds the entries.
// Depends on iaisd_pkg and iaisd_cell.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. The entries sit in a
// row of DEPTH cells; an insert, delete or overwrite changes all the cells it
// affects at once, in the edit state. Sum, maximum, minimum, search and read results then
// travel cell to cell, one cell per clock, through the register of each cell.
// done is high for one cycle, once the row has settled, with every result
// field valid; the result must be taken at the edge that ends that cycle.
// busy stays high until done, so a new command is taken only after the
// previous one has finished. No clearing pass is needed after reset: entries
// beyond the stored count are never used.
module indexed_array_insert_delete_search_top import iaisd_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            command,
	input  logic [POS_W-1:0]      position,
	input  logic [DATA_W-1:0]     value,
	output logic                  done,
	output logic [2:0]            status,
	output logic [DATA_W-1:0]     read_value,
	output logic [POS_W-1:0]      found_position,
	output logic [CNT_OUT_W-1:0]  entry_count,
	output logic [SUM_W-1:0]      total,
	output logic [DATA_W-1:0]     largest,
	output logic [DATA_W-1:0]     smallest
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DEPTH - 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  sweep_q, sweep_d;
	logic [CNT_W-1:0]  count_q;

	cmd_t              cmd_q;
	status_t           status_q;
	edit_op_t          op_q;
	logic [PW-1:0]     pos_q;
	logic [DATA_W-1:0] val_q;

	logic              accept;
	status_t           status_d;
	edit_op_t          op_d;
	logic [PW-1:0]     pos_d;
	logic [CNT_W-1:0]  cnt_d;
	logic [PW-1:0]     pos_ext;
	logic [PW-1:0]     cnt_ext;
	logic              is_full;
	logic              is_empty;

	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] entry_w [DEPTH];
	carry_t            carry_w [DEPTH+1];
	carry_t            res;

	assign accept   = start && (state_q == S_IDLE);
	assign pos_ext  = PW'(position);
	assign cnt_ext  = PW'(count_q);
	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	// Command decode: status checks, edit operation and new count.
	always_comb begin
		status_d = ST_OK;
		op_d     = EDIT_NONE;
		pos_d    = pos_ext;
		cnt_d    = count_q;
		case (cmd_t'(command))
			CMD_APPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					op_d  = EDIT_INSERT;
					pos_d = cnt_ext;
					cnt_d = count_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_d = ST_BADPOS;
				end else if (is_full) begin
					status_d = ST_FULL;
				end else begin
					op_d  = EDIT_INSERT;
					cnt_d = count_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = ST_BADPOS;
				end else begin
					op_d  = EDIT_DELETE;
					cnt_d = count_q - 1'b1;
				end
			end
			CMD_OVERWRITE: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = ST_BADPOS;
				end else begin
					op_d = EDIT_WRITE;
				end
			end
			CMD_READ: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = ST_BADPOS;
				end
			end
			CMD_SEARCH: begin
				status_d = ST_NOTFOUND;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Sequencer: next state and sweep counter.
	always_comb begin
		state_d = state_q;
		sweep_d = sweep_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EDIT;
				end
			end
			S_EDIT: begin
				state_d = S_SWEEP;
				sweep_d = '0;
			end
			S_SWEEP: begin
				if (sweep_q == LAST_STEP) begin
					state_d = S_DONE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sweep_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			if (accept) begin
				count_q <= cnt_d;
			end
		end
	end

	// Command fields held for the edit cycle and the sweep.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(command);
			status_q <= status_d;
			op_q     <= op_d;
			pos_q    <= pos_d;
			val_q    <= value;
		end
	end

	// The edit is applied only in the edit cycle; the value doubles as search key.
	assign ctrl.op    = (state_q == S_EDIT) ? op_q : EDIT_NONE;
	assign ctrl.value = val_q;

	assign carry_w[0] = CARRY_INIT;

	// Row of cells, each linked to its neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		iaisd_cell #(
			.INDEX (i),
			.CNT_W (CNT_W),
			.PW    (PW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.pos         (pos_q),
			.count       (count_q),
			.left_entry  (left_w),
			.right_entry (right_w),
			.carry_in    (carry_w[i]),
			.entry       (entry_w[i]),
			.carry_out   (carry_w[i+1])
		);
	end

	// Sum, extremes, search and read results come from the partial results at the end of the row.
	assign res  = carry_w[DEPTH];
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		status         = status_q;
		read_value     = '0;
		found_position = '0;
		if (cmd_q == CMD_SEARCH) begin
			status = res.found ? ST_OK : ST_NOTFOUND;
			if (res.found) begin
				found_position = res.fpos;
			end
		end
		if ((cmd_q == CMD_READ) && (status_q == ST_OK)) begin
			read_value = res.rd;
		end
	end

	assign entry_count = CNT_OUT_W'(count_q);
	assign total       = res.sum;
	assign largest     = res.any ? res.max_v : '0;
	assign smallest    = res.any ? res.min_v : '0;

endmodule

// ===== hw/rtl/iaisd_checker.sv =====
// Port-level checker for the indexed array list top level, and the bind that
// attaches it. Depends on iaisd_pkg and indexed_array_insert_delete_search_top.
`timescale 1ns / 1ps

module iaisd_checker import iaisd_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [2:0]           status,
	input logic [CNT_OUT_W-1:0] entry_count,
	input logic [DATA_W-1:0]    largest,
	input logic [DATA_W-1:0]    smallest
);

	// A transfer in makes the block busy, and no result comes in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command did not start work");

	// After a result the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block still busy after result");

	// A result is only shown while a command is in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without a command in progress");

	// The maximum never falls below the minimum.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(largest) >= $signed(smallest)))
		else $error("largest below smallest");

	// A full error means the array holds DEPTH entries.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (entry_count == CNT_OUT_W'(DEPTH)))
		else $error("full status with array not full");

endmodule

bind indexed_array_insert_delete_search_top iaisd_checker #(
	.DEPTH (DEPTH)
) u_iaisd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.entry_count (entry_count),
	.largest     (largest),
	.smallest    (smallest)
);
